@@ src/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the event queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Condition that must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

@@ src/stq_pkg.sv @@
// Types, constants and helper functions of the sorted timed event queue.
package stq_pkg;

  // Queue depth and stored kind width.
  localparam int DEPTH     = 16;
  localparam int KIND_BITS = 8;
  localparam int COUNT_W   = $clog2(DEPTH + 1);

  // Port widths fixed by the item format.
  localparam int KIND_PORT_W = 8;
  localparam int DELAY_W     = 32;
  localparam int ELAPSED_W   = 20;
  localparam int OCC_W       = 5;

  // Remaining time: signed Q18.16, saturating at its minimum.
  localparam int TIME_W = 34;
  typedef logic signed [TIME_W-1:0] time_t;
  localparam time_t TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};

  typedef logic [KIND_BITS-1:0] kind_t;

  // Item modes.
  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // One stored event.
  typedef struct packed {
    time_t t;
    kind_t k;
  } entry_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic                 do_add;
    logic                 do_tick;
    logic                 pop;
    time_t                delay;
    kind_t                kind;
    logic [ELAPSED_W-1:0] elapsed;
  } ctl_t;

  // Keep the low KIND_BITS of the kind port.
  function automatic kind_t kind_in(input logic [KIND_PORT_W-1:0] k);
    logic [KIND_BITS+KIND_PORT_W-1:0] w;
    w = {{KIND_BITS{1'b0}}, k};
    return w[KIND_BITS-1:0];
  endfunction

  // Widen or trim a stored kind to the port width.
  function automatic logic [KIND_PORT_W-1:0] kind_out(input kind_t k);
    logic [KIND_BITS+KIND_PORT_W-1:0] w;
    w = {{KIND_PORT_W{1'b0}}, k};
    return w[KIND_PORT_W-1:0];
  endfunction

  // Report the fill count in the occupancy port width.
  function automatic logic [OCC_W-1:0] occ_out(input logic [COUNT_W-1:0] c);
    logic [COUNT_W+OCC_W-1:0] w;
    w = {{OCC_W{1'b0}}, c};
    return w[OCC_W-1:0];
  endfunction

endpackage

@@ src/stq_cell.sv @@
// One cell of the event chain: holds one entry, inserts, ages and shifts.
module stq_cell (
  input  logic            clk,
  input  logic            load,
  input  stq_pkg::ctl_t   ctl,
  input  logic            occ,
  input  logic            occ_prev,
  input  logic            gt_prev,
  input  stq_pkg::entry_t left,
  input  stq_pkg::entry_t right_aged,
  output stq_pkg::entry_t cur,
  output stq_pkg::entry_t aged,
  output logic            gt
);

  stq_pkg::entry_t        ent;
  stq_pkg::entry_t        ent_next;
  logic signed [stq_pkg::TIME_W:0] diff;
  logic                   tail;

  assign cur = ent;

  // An occupied entry with a later time than the new event moves back.
  assign gt   = occ && (ent.t > stq_pkg::time_t'(ctl.delay));
  assign tail = !occ && occ_prev;

  // Age by the frame time with saturation at the minimum.
  always_comb begin
    diff   = {ent.t[stq_pkg::TIME_W-1], ent.t}
           - $signed({{(stq_pkg::TIME_W + 1 - stq_pkg::ELAPSED_W){1'b0}}, ctl.elapsed});
    aged.k = ent.k;
    if (diff[stq_pkg::TIME_W] && !diff[stq_pkg::TIME_W-1]) begin
      aged.t = stq_pkg::TIME_MIN;
    end else begin
      aged.t = diff[stq_pkg::TIME_W-1:0];
    end
  end

  // Select the next content of this cell.
  always_comb begin
    ent_next = ent;
    if (ctl.do_add) begin
      if (gt || tail) begin
        if (gt_prev) begin
          ent_next = left;
        end else begin
          ent_next.t = ctl.delay;
          ent_next.k = ctl.kind;
        end
      end
    end else if (ctl.do_tick) begin
      ent_next = ctl.pop ? right_aged : aged;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent <= ent_next;
    end
  end

endmodule

@@ src/sorted_timed_event_queue.sv @@
// Top level of the sorted timed event queue: cell chain, fill count and result register.
// The queue holds up to DEPTH events in a chain of cells kept in ascending order of
// remaining time. It takes one item per cycle: every cell compares, ages and shifts
// in parallel in the cycle an item is accepted, and the result appears in the output
// register on the next cycle. The input is ready whenever the output register is empty
// or being emptied, so a stalled result holds off the input until it is taken. An add
// finds its place ahead of the first strictly later entry; a tick (only while enable is
// set and the queue is non-empty) ages all entries and fires at most the expired head.
// No clearing pass is needed after reset; configuration writes are always accepted.
`include "assert_macros.svh"

module sorted_timed_event_queue (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_data,
  input  logic                               item_valid,
  output logic                               item_ready,
  input  logic                               mode,
  input  logic [stq_pkg::KIND_PORT_W-1:0]    kind,
  input  logic [stq_pkg::DELAY_W-1:0]        delay,
  input  logic [stq_pkg::ELAPSED_W-1:0]      elapsed,
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic                               fired,
  output logic [stq_pkg::KIND_PORT_W-1:0]    fired_kind,
  output logic                               dropped,
  output logic [stq_pkg::OCC_W-1:0]          occupancy
);

  logic                          enable;
  logic [stq_pkg::COUNT_W-1:0]   count;
  logic [stq_pkg::COUNT_W-1:0]   count_next;
  logic                          accept;
  logic                          full;
  logic                          nonempty;
  logic [stq_pkg::DEPTH-1:0]     occ;
  logic [stq_pkg::DEPTH-1:0]     gt;
  stq_pkg::entry_t               cur  [stq_pkg::DEPTH];
  stq_pkg::entry_t               aged [stq_pkg::DEPTH];
  stq_pkg::ctl_t                 ctl;

  assign cfg_ready  = 1'b1;
  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;
  assign full       = (count == stq_pkg::COUNT_W'(stq_pkg::DEPTH));
  assign nonempty   = (count != '0);

  // Enable register.
  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      enable <= cfg_data;
    end
  end

  // Command to the cells; the head fires when its aged time is negative.
  always_comb begin
    ctl.do_add  = (mode == stq_pkg::MODE_ADD) && !full;
    ctl.do_tick = (mode == stq_pkg::MODE_TICK) && enable && nonempty;
    ctl.pop     = ctl.do_tick && aged[0].t[stq_pkg::TIME_W-1];
    ctl.delay   = stq_pkg::time_t'({{(stq_pkg::TIME_W - stq_pkg::DELAY_W){1'b0}}, delay});
    ctl.kind    = stq_pkg::kind_in(kind);
    ctl.elapsed = elapsed;
  end

  // Cell chain.
  for (genvar i = 0; i < stq_pkg::DEPTH; i++) begin : g_cell
    stq_pkg::entry_t left_in;
    stq_pkg::entry_t right_in;
    logic            occ_prev_in;
    logic            gt_prev_in;

    assign occ[i] = stq_pkg::COUNT_W'(i) < count;

    if (i == 0) begin : g_head
      assign left_in     = '0;
      assign occ_prev_in = 1'b1;
      assign gt_prev_in  = 1'b0;
    end else begin : g_body
      assign left_in     = cur[i-1];
      assign occ_prev_in = occ[i-1];
      assign gt_prev_in  = gt[i-1];
    end

    if (i == stq_pkg::DEPTH - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_inner
      assign right_in = aged[i+1];
    end

    stq_cell u_cell (
      .clk        (clk),
      .load       (accept),
      .ctl        (ctl),
      .occ        (occ[i]),
      .occ_prev   (occ_prev_in),
      .gt_prev    (gt_prev_in),
      .left       (left_in),
      .right_aged (right_in),
      .cur        (cur[i]),
      .aged       (aged[i]),
      .gt         (gt[i])
    );
  end

  // Fill count.
  always_comb begin
    count_next = count;
    if (ctl.do_add) begin
      count_next = count + 1'b1;
    end else if (ctl.pop) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fired      <= ctl.pop;
      fired_kind <= ctl.pop ? stq_pkg::kind_out(aged[0].k) : '0;
      dropped    <= (mode == stq_pkg::MODE_ADD) && full;
      occupancy  <= stq_pkg::occ_out(count_next);
    end
  end

  // The fill count never passes the depth.
  `ASSERT_NEVER(a_count_bound, clk, rst, count > stq_pkg::COUNT_W'(stq_pkg::DEPTH))
  // An add on a full queue yields a dropped result and leaves the count alone.
  `ASSERT_CLK(a_drop_full, clk, rst, accept && (mode == stq_pkg::MODE_ADD) && full |=> result_valid && dropped && (count == $past(count)))
  // A fired event removes exactly one entry.
  `ASSERT_CLK(a_pop_count, clk, rst, accept && ctl.pop |=> fired && (count == $past(count) - 1'b1))
  // The head is never later than the second entry.
  `ASSERT_CLK(a_head_order, clk, rst, occ[1] |-> cur[0].t <= cur[1].t)

endmodule
